// File: hdl/crlru_pkg.sv
`default_nettype none
package crlru_pkg;
	localparam int ENTRIES_DEF = 16;
	localparam int VALUE_BITS_DEF = 64;
	localparam int KEY_W = 32;
	localparam int USE_W = 16;
	localparam int STAMP_W = 32;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [1:0] CMD_GET = 2'd0;
	localparam logic [1:0] CMD_PUT = 2'd1;
	localparam logic [1:0] CMD_CLR = 2'd2;
	localparam logic [1:0] POL_LRU = 2'd0;
	localparam logic [1:0] POL_MRU = 2'd1;
	localparam logic [1:0] POL_MFU = 2'd2;
	localparam logic [1:0] POL_BAD = 2'd3;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_step;
		logic commit;
		logic emit;
	} crlru_cmd_t;

	typedef struct packed {
		logic scan_last;
	} crlru_sts_t;
endpackage
`default_nettype wire

// File: hdl/crlru_ctrl.sv
`default_nettype none
module crlru_ctrl
	import crlru_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	output crlru_cmd_t cmd_o,
	input  wire crlru_sts_t sts_i
);
	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_EMIT} state_t;
	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_SCAN;
				S_SCAN: if (sts_i.scan_last) state_q <= S_COMMIT;
				S_COMMIT: state_q <= S_EMIT;
				S_EMIT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd_o = '0;
		cmd_o.load = (state_q == S_IDLE) && start;
		cmd_o.scan_clr = cmd_o.load;
		cmd_o.scan_step = (state_q == S_SCAN);
		cmd_o.commit = (state_q == S_COMMIT);
		cmd_o.emit = (state_q == S_EMIT);
	end

	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_o.emit |=> !cmd_o.emit) else $error("double emit");
	a_commit_before_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_o.emit |-> $past(cmd_o.commit)) else $error("emit without commit");
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
endmodule
`default_nettype wire

// File: hdl/crlru_dp.sv
`default_nettype none
module crlru_dp
	import crlru_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
)(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire crlru_cmd_t cmd_i,
	output crlru_sts_t sts_o,
	input  wire logic [CAP_W-1:0] cap_i,
	input  wire logic [1:0] cmd,
	input  wire logic signed [KEY_W-1:0] key,
	input  wire logic [63:0] value,
	input  wire logic [1:0] policy,
	output logic done,
	output logic hit,
	output logic [63:0] read_value,
	output logic evicted,
	output logic signed [KEY_W-1:0] evicted_key
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	logic [ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0] key_q [ENTRIES];
	logic [VALUE_BITS-1:0] data_q [ENTRIES];
	logic [USE_W-1:0] use_q [ENTRIES];
	logic [STAMP_W-1:0] stamp_q [ENTRIES];
	logic [STAMP_W-1:0] ctr_q;
	logic [CW-1:0] count_q;

	logic [1:0] op_q, pol_q;
	logic [KEY_W-1:0] k_q;
	logic [VALUE_BITS-1:0] v_q;

	logic [IW-1:0] idx_q;
	logic found_q, vfound_q, free_found_q;
	logic [IW-1:0] fidx_q, vidx_q, free_q;
	logic [STAMP_W-1:0] vage_q;
	logic [USE_W-1:0] vuse_q;

	logic hit_q, ev_q;
	logic [63:0] rv_q;
	logic [KEY_W-1:0] ek_q;
	logic done_q;

	logic [STAMP_W-1:0] age_c;
	logic better_c;
	logic [CW-1:0] cap_eff;

	assign sts_o.scan_last = (32'(idx_q) == ENTRIES - 1);
	assign age_c = ctr_q - stamp_q[idx_q];

	always_comb begin
		better_c = 1'b0;
		case (pol_q)
			POL_LRU: better_c = age_c > vage_q;
			POL_MRU: better_c = age_c < vage_q;
			default: better_c = (use_q[idx_q] > vuse_q) ||
				((use_q[idx_q] == vuse_q) && (age_c > vage_q));
		endcase
		if (cap_i == '0) cap_eff = CW'(1);
		else if (32'(cap_i) > ENTRIES) cap_eff = CW'(ENTRIES);
		else cap_eff = CW'(cap_i);
	end

	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			op_q <= cmd;
			pol_q <= policy;
			k_q <= key;
			v_q <= value[VALUE_BITS-1:0];
		end
		if (cmd_i.scan_clr) begin
			idx_q <= '0;
			found_q <= 1'b0;
			vfound_q <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd_i.scan_step) begin
			if (valid_q[idx_q]) begin
				if (!found_q && key_q[idx_q] == k_q) begin
					found_q <= 1'b1;
					fidx_q <= idx_q;
				end
				if (!vfound_q || better_c) begin
					vfound_q <= 1'b1;
					vidx_q <= idx_q;
					vage_q <= age_c;
					vuse_q <= use_q[idx_q];
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_q <= idx_q;
			end
			if (!sts_o.scan_last) idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ctr_q <= '0;
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd_i.emit;
			if (cmd_i.commit) begin
				hit_q <= 1'b0;
				rv_q <= '0;
				ev_q <= 1'b0;
				ek_q <= '0;
				case (op_q)
					CMD_GET: if (found_q) begin
						hit_q <= 1'b1;
						rv_q <= 64'(data_q[fidx_q]);
						if (use_q[fidx_q] != '1) use_q[fidx_q] <= use_q[fidx_q] + 1'b1;
						stamp_q[fidx_q] <= ctr_q;
						ctr_q <= ctr_q + 1'b1;
					end
					CMD_PUT: if (found_q) begin
						hit_q <= 1'b1;
						data_q[fidx_q] <= v_q;
						if (use_q[fidx_q] != '1) use_q[fidx_q] <= use_q[fidx_q] + 1'b1;
						stamp_q[fidx_q] <= ctr_q;
						ctr_q <= ctr_q + 1'b1;
					end else if (count_q >= cap_eff) begin
						if (pol_q != POL_BAD && vfound_q) begin
							ev_q <= 1'b1;
							ek_q <= key_q[vidx_q];
							key_q[vidx_q] <= k_q;
							data_q[vidx_q] <= v_q;
							use_q[vidx_q] <= USE_W'(1);
							stamp_q[vidx_q] <= ctr_q;
							ctr_q <= ctr_q + 1'b1;
						end
					end else if (free_found_q) begin
						valid_q[free_q] <= 1'b1;
						key_q[free_q] <= k_q;
						data_q[free_q] <= v_q;
						use_q[free_q] <= USE_W'(1);
						stamp_q[free_q] <= ctr_q;
						ctr_q <= ctr_q + 1'b1;
						count_q <= count_q + 1'b1;
					end
					CMD_CLR: begin
						valid_q <= '0;
						count_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	assign done = done_q;
	assign hit = done_q & hit_q;
	assign read_value = done_q ? rv_q : '0;
	assign evicted = done_q & ev_q;
	assign evicted_key = done_q ? ek_q : '0;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= ENTRIES) else $error("fill count overflow");
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) == $countones(valid_q)) else $error("fill count mismatch");
	a_ev_put: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_i.commit && op_q != CMD_PUT) |=> !ev_q) else $error("evict off put");
endmodule
`default_nettype wire

// File: hdl/cache_replacement_lru_mru_mfu.sv
// A new start is taken only while idle; busy is high during the work.
// The scan reads one entry per cycle for key match, free slot and victim.
// Result is shown one cycle with done; the receiver cannot stall.
// Reset clears valid bits, stamp counter, fill count; capacity resets to 16.
`default_nettype none
module cache_replacement_lru_mru_mfu
	import crlru_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
)(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic [1:0] cmd,
	input  wire logic signed [KEY_W-1:0] key,
	input  wire logic [63:0] value,
	input  wire logic [1:0] policy,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [CAP_W-1:0] cfg_data,
	output logic done,
	output logic hit,
	output logic [63:0] read_value,
	output logic evicted,
	output logic signed [KEY_W-1:0] evicted_key
);
	logic [CAP_W-1:0] cap_q;
	crlru_cmd_t cmd_w;
	crlru_sts_t sts_w;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= CAP_RESET;
		else if (cfg_valid) cap_q <= cfg_data;
	end

	crlru_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd_o(cmd_w), .sts_i(sts_w)
	);

	crlru_dp #(.ENTRIES(ENTRIES), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd_i(cmd_w), .sts_o(sts_w), .cap_i(cap_q),
		.cmd(cmd), .key(key), .value(value), .policy(policy), .done(done),
		.hit(hit), .read_value(read_value), .evicted(evicted),
		.evicted_key(evicted_key)
	);
endmodule
`default_nettype wire
